>>> rtl/core/sit_pkg.sv
package sit_pkg;

  // quotient bits of the crossing fraction
  localparam int DIV_BITS = 32;
  // fractional bits added to the squared length before its root
  localparam int SQRT_SHIFT = 16;
  // width of the distance result
  localparam int DIST_WIDTH = 25;
  localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

endpackage

>>> rtl/core/sit_front.sv
module sit_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic signed [COORD_WIDTH-1:0]    in_a_start_x,
  input  logic signed [COORD_WIDTH-1:0]    in_a_start_y,
  input  logic signed [COORD_WIDTH-1:0]    in_a_end_x,
  input  logic signed [COORD_WIDTH-1:0]    in_a_end_y,
  input  logic signed [COORD_WIDTH-1:0]    in_b_start_x,
  input  logic signed [COORD_WIDTH-1:0]    in_b_start_y,
  input  logic signed [COORD_WIDTH-1:0]    in_b_end_x,
  input  logic signed [COORD_WIDTH-1:0]    in_b_end_y,
  input  logic                             q_full,
  output logic                             f_push,
  output logic                             f_ok,
  output logic [2*COORD_WIDTH+2:0]         f_n,
  output logic [2*COORD_WIDTH+2:0]         f_dp,
  output logic [2*COORD_WIDTH+2:0]         f_l2
);

  localparam int D = COORD_WIDTH + 1;
  localparam int P = 2 * D;
  localparam int S = 2 * D + 1;

  logic fe;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // stage 1 differences
  logic signed [D-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
  logic signed [D-1:0] dx_r, dy_r, d1x_r, d1y_r, d2x_r, d2y_r, ex_r, ey_r;

  // stage 2 products
  logic signed [P-1:0] xx_r, yy_r, p1a_r, p1b_r, p2a_r, p2b_r;
  logic signed [P-1:0] s1a_r, s1b_r, s2a_r, s2b_r, na_r, nb_r, da_r, db_r;

  // stage 3 sums
  logic signed [S-1:0] l2_r, p1_r, p2_r, s1_r, s2_r, n3_r, dp3_r;

  // stage 4 rejects and sign normalize
  logic                rej4_r;
  logic signed [S:0]   n4_r, dp4_r;
  logic signed [S-1:0] l24_r;

  // stage 5 final test
  logic                ok5_r;
  logic [S-1:0]        n5_r, dp5_r, l25_r;

  function automatic logic signed [S-1:0] ext(input logic signed [P-1:0] v);
    return {v[P-1], v};
  endfunction

  // pipeline moves unless the last stage is blocked by the queue
  assign fe      = !(v5_r && q_full);
  assign in_full = !fe;
  assign f_push  = fe && v5_r;
  assign f_ok    = ok5_r;
  assign f_n     = n5_r;
  assign f_dp    = dp5_r;
  assign f_l2    = l25_r;

  assign asx = {in_a_start_x[COORD_WIDTH-1], in_a_start_x};
  assign asy = {in_a_start_y[COORD_WIDTH-1], in_a_start_y};
  assign aex = {in_a_end_x[COORD_WIDTH-1], in_a_end_x};
  assign aey = {in_a_end_y[COORD_WIDTH-1], in_a_end_y};
  assign bsx = {in_b_start_x[COORD_WIDTH-1], in_b_start_x};
  assign bsy = {in_b_start_y[COORD_WIDTH-1], in_b_start_y};
  assign bex = {in_b_end_x[COORD_WIDTH-1], in_b_end_x};
  assign bey = {in_b_end_y[COORD_WIDTH-1], in_b_end_y};

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (fe) begin
      v1_r <= in_push;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (fe) begin
      dx_r  <= aex - asx;
      dy_r  <= aey - asy;
      d1x_r <= bsx - asx;
      d1y_r <= bsy - asy;
      d2x_r <= bex - asx;
      d2y_r <= bey - asy;
      ex_r  <= bex - bsx;
      ey_r  <= bey - bsy;

      xx_r  <= dx_r * dx_r;
      yy_r  <= dy_r * dy_r;
      p1a_r <= dx_r * d1x_r;
      p1b_r <= dy_r * d1y_r;
      p2a_r <= dx_r * d2x_r;
      p2b_r <= dy_r * d2y_r;
      s1a_r <= dy_r * d1x_r;
      s1b_r <= dx_r * d1y_r;
      s2a_r <= dy_r * d2x_r;
      s2b_r <= dx_r * d2y_r;
      na_r  <= d1x_r * d2y_r;
      nb_r  <= d1y_r * d2x_r;
      da_r  <= dx_r * ey_r;
      db_r  <= dy_r * ex_r;

      l2_r  <= ext(xx_r) + ext(yy_r);
      p1_r  <= ext(p1a_r) + ext(p1b_r);
      p2_r  <= ext(p2a_r) + ext(p2b_r);
      s1_r  <= ext(s1a_r) - ext(s1b_r);
      s2_r  <= ext(s2a_r) - ext(s2b_r);
      n3_r  <= ext(na_r) - ext(nb_r);
      dp3_r <= ext(da_r) - ext(db_r);

      rej4_r <= (l2_r == '0)
             || (p1_r <= 0 && p2_r <= 0)
             || (p1_r >= l2_r && p2_r >= l2_r)
             || (s1_r > 0 && s2_r > 0)
             || (s1_r < 0 && s2_r < 0)
             || (s1_r == s2_r);
      n4_r   <= dp3_r[S-1] ? -{n3_r[S-1], n3_r} : {n3_r[S-1], n3_r};
      dp4_r  <= dp3_r[S-1] ? -{dp3_r[S-1], dp3_r} : {dp3_r[S-1], dp3_r};
      l24_r  <= l2_r;

      ok5_r <= !rej4_r && (n4_r > 0) && (n4_r < dp4_r);
      n5_r  <= n4_r[S-1:0];
      dp5_r <= dp4_r[S-1:0];
      l25_r <= l24_r;
    end
  end

endmodule

>>> rtl/core/sit_queue.sv
module sit_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/core/sit_back.sv
module sit_back #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  logic                              q_ok,
  input  logic [2*COORD_WIDTH+2:0]          q_n,
  input  logic [2*COORD_WIDTH+2:0]          q_dp,
  input  logic [2*COORD_WIDTH+2:0]          q_l2,
  output logic                              q_pop,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic                              out_hit,
  output logic [sit_pkg::DIST_WIDTH-1:0]    out_crossing_distance
);

  localparam int D   = COORD_WIDTH + 1;
  localparam int S   = 2 * D + 1;
  localparam int QB  = sit_pkg::DIV_BITS;
  localparam int R   = D + sit_pkg::SQRT_SHIFT / 2;
  localparam int TW  = 2 * R + 2;
  localparam int NS  = (R > QB) ? R : QB;
  localparam int LH  = R / 2;
  localparam int HH  = R - LH;
  localparam int PW  = QB + R;
  localparam int DW2 = (R > sit_pkg::DIST_WIDTH) ? R : sit_pkg::DIST_WIDTH;

  logic be;

  // step stages: each yields a quotient bit while k < QB and a root bit while k < R
  logic          v_r     [NS];
  logic          ok_r    [NS];
  logic [S-1:0]  dp_r    [NS];
  logic [S-1:0]  dr_r    [NS];
  logic [QB-1:0] q_r     [NS];
  logic [TW-1:0] srem_r  [NS];
  logic [R-1:0]  sroot_r [NS];

  logic          v_nxt     [NS];
  logic          ok_nxt    [NS];
  logic [S-1:0]  dp_nxt    [NS];
  logic [S-1:0]  dr_nxt    [NS];
  logic [QB-1:0] q_nxt     [NS];
  logic [TW-1:0] srem_nxt  [NS];
  logic [R-1:0]  sroot_nxt [NS];

  // partial products and output stage
  logic            vm_r, okm_r;
  logic [QB+LH-1:0] pl_r;
  logic [QB+HH-1:0] ph_r;
  logic            vo_r, hit_r;
  logic [sit_pkg::DIST_WIDTH-1:0] dist_r;

  logic [PW-1:0]   prod;
  logic [DW2-1:0]  hi_e;
  logic [sit_pkg::DIST_WIDTH-1:0] dist_nxt;

  // whole back pipeline stalls only while the result is not taken
  assign be        = !(vo_r && !out_pop);
  assign q_pop     = be && !q_empty;
  assign out_empty = !vo_r;
  assign out_hit   = hit_r;
  assign out_crossing_distance = dist_r;

  // restoring divide and digit-by-digit root, stage by stage
  always_comb begin
    logic          cv, cok;
    logic [S-1:0]  cdp, cdr;
    logic [QB-1:0] cq;
    logic [TW-1:0] crem, trial;
    logic [R-1:0]  croot;
    logic [S:0]    r2;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        cv    = !q_empty;
        cok   = q_ok;
        cdp   = q_dp;
        cdr   = q_n;
        cq    = '0;
        crem  = TW'(q_l2) << sit_pkg::SQRT_SHIFT;
        croot = '0;
      end else begin
        cv    = v_r[k-1];
        cok   = ok_r[k-1];
        cdp   = dp_r[k-1];
        cdr   = dr_r[k-1];
        cq    = q_r[k-1];
        crem  = srem_r[k-1];
        croot = sroot_r[k-1];
      end
      v_nxt[k]  = cv;
      ok_nxt[k] = cok;
      dp_nxt[k] = cdp;
      // quotient bit
      r2 = {cdr, 1'b0};
      if (k < QB) begin
        if (r2 >= {1'b0, cdp}) begin
          dr_nxt[k] = S'(r2 - {1'b0, cdp});
          q_nxt[k]  = {cq[QB-2:0], 1'b1};
        end else begin
          dr_nxt[k] = S'(r2);
          q_nxt[k]  = {cq[QB-2:0], 1'b0};
        end
      end else begin
        dr_nxt[k] = cdr;
        q_nxt[k]  = cq;
      end
      // root bit
      trial = '0;
      if (k < R) begin
        trial = (TW'(croot) << (R - k)) + (TW'(1) << (2 * (R - 1 - k)));
        if (crem >= trial) begin
          srem_nxt[k]  = crem - trial;
          sroot_nxt[k] = croot | (R'(1) << (R - 1 - k));
        end else begin
          srem_nxt[k]  = crem;
          sroot_nxt[k] = croot;
        end
      end else begin
        srem_nxt[k]  = crem;
        sroot_nxt[k] = croot;
      end
    end
  end

  // scale and saturate, zero for a rejected pair
  always_comb begin
    prod     = PW'(pl_r) + (PW'(ph_r) << LH);
    hi_e     = DW2'(prod[PW-1:QB]);
    if (!okm_r) begin
      dist_nxt = '0;
    end else if (hi_e > DW2'(sit_pkg::DIST_MAX)) begin
      dist_nxt = sit_pkg::DIST_MAX;
    end else begin
      dist_nxt = hi_e[sit_pkg::DIST_WIDTH-1:0];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) begin
        v_r[k] <= 1'b0;
      end
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (be) begin
      for (int k = 0; k < NS; k++) begin
        v_r[k] <= v_nxt[k];
      end
      vm_r <= v_r[NS-1];
      vo_r <= vm_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (be) begin
      for (int k = 0; k < NS; k++) begin
        ok_r[k]    <= ok_nxt[k];
        dp_r[k]    <= dp_nxt[k];
        dr_r[k]    <= dr_nxt[k];
        q_r[k]     <= q_nxt[k];
        srem_r[k]  <= srem_nxt[k];
        sroot_r[k] <= sroot_nxt[k];
      end
      okm_r  <= ok_r[NS-1];
      pl_r   <= q_r[NS-1] * sroot_r[NS-1][LH-1:0];
      ph_r   <= q_r[NS-1] * sroot_r[NS-1][R-1:LH];
      hit_r  <= okm_r;
      dist_r <= dist_nxt;
    end
  end

endmodule

>>> rtl/core/segment_intersection_test_top.sv
// channel  ports                                 request
// in       in_push / in_full, in_<coords>        eight coordinates of segments A and B
// out      out_pop / out_empty, out_hit, out_... one hit flag and crossing distance
//
// one request per cycle sustained while neither pipeline stalls; the path is 5 front
// stages, the queue, and max(32, COORD_WIDTH+9) divide/root stages plus 2 scaling stages
// the front pipeline stalls only when the 4-entry queue is full
// the back pipeline stalls only while a result waits with out_pop low
// synchronous active-low reset clears valid state only
module segment_intersection_test_top #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic signed [COORD_WIDTH-1:0]     in_a_start_x,
  input  logic signed [COORD_WIDTH-1:0]     in_a_start_y,
  input  logic signed [COORD_WIDTH-1:0]     in_a_end_x,
  input  logic signed [COORD_WIDTH-1:0]     in_a_end_y,
  input  logic signed [COORD_WIDTH-1:0]     in_b_start_x,
  input  logic signed [COORD_WIDTH-1:0]     in_b_start_y,
  input  logic signed [COORD_WIDTH-1:0]     in_b_end_x,
  input  logic signed [COORD_WIDTH-1:0]     in_b_end_y,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic                              out_hit,
  output logic [sit_pkg::DIST_WIDTH-1:0]    out_crossing_distance
);

  localparam int S  = 2 * COORD_WIDTH + 3;
  localparam int QW = 1 + 3 * S;

  logic          f_push, f_ok, q_full, q_empty, q_pop;
  logic [S-1:0]  f_n, f_dp, f_l2;
  logic [QW-1:0] q_rdata;

  // classify
  sit_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_a_start_x (in_a_start_x),
    .in_a_start_y (in_a_start_y),
    .in_a_end_x   (in_a_end_x),
    .in_a_end_y   (in_a_end_y),
    .in_b_start_x (in_b_start_x),
    .in_b_start_y (in_b_start_y),
    .in_b_end_x   (in_b_end_x),
    .in_b_end_y   (in_b_end_y),
    .q_full       (q_full),
    .f_push       (f_push),
    .f_ok         (f_ok),
    .f_n          (f_n),
    .f_dp         (f_dp),
    .f_l2         (f_l2)
  );

  // decoupling queue
  sit_queue #(.DATA_W(QW), .DEPTH(4)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata ({f_ok, f_n, f_dp, f_l2}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // divide, root and scale
  sit_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .q_ok                  (q_rdata[QW-1]),
    .q_n                   (q_rdata[3*S-1:2*S]),
    .q_dp                  (q_rdata[2*S-1:S]),
    .q_l2                  (q_rdata[S-1:0]),
    .q_pop                 (q_pop),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_hit               (out_hit),
    .out_crossing_distance (out_crossing_distance)
  );

  // a miss always reports zero distance
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_hit) |-> (out_crossing_distance == '0))
    else $error("miss with nonzero distance");

  // the front never pushes into a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    !(f_push && q_full))
    else $error("push into full queue");

  // a waiting result is held until popped
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_crossing_distance)))
    else $error("result dropped while stalled");

endmodule

>>> bench/segment_intersection_test_top_tb.sv
`timescale 1ns / 1ps

module segment_intersection_test_top_tb;

  localparam int CW = 16;
  localparam int NUM_ITEMS = 1200;
  localparam int NUM_DIRECTED = 12;
  localparam int PAUSE_AT = 700;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic signed [CW-1:0] ax, ay, ex, ey, b1x, b1y, b2x, b2y;
  } seg_pair_t;

  typedef struct packed {
    logic                           hit;
    logic [sit_pkg::DIST_WIDTH-1:0] distance;
  } crossing_t;

  typedef struct {
    seg_pair_t pair;
    bit        typed;
    crossing_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  seg_pair_t cur = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_hit;
  logic [sit_pkg::DIST_WIDTH-1:0] out_crossing_distance;

  crossing_t expected_crossings[$];
  directed_row_t directed_rows[NUM_DIRECTED];
  int errors = 0;
  bit hold_req = 1'b0;
  bit stim_done = 1'b0;

  always #2 clk = ~clk;

  segment_intersection_test_top #(.COORD_WIDTH(CW)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_a_start_x(cur.ax), .in_a_start_y(cur.ay),
    .in_a_end_x(cur.ex), .in_a_end_y(cur.ey),
    .in_b_start_x(cur.b1x), .in_b_start_y(cur.b1y),
    .in_b_end_x(cur.b2x), .in_b_end_y(cur.b2y),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_hit(out_hit), .out_crossing_distance(out_crossing_distance)
  );

  // exact integer crossing test and fixed-point distance
  function automatic crossing_t predict_crossing(seg_pair_t p);
    logic signed [127:0] ox, oy, dx, dy, d1x, d1y, d2x, d2y;
    logic signed [127:0] l2, p1, p2, s1, s2, n, dp;
    logic [127:0] uq, lf, cand, rad, prod;
    crossing_t r;
    r = '0;
    ox = p.ax;
    oy = p.ay;
    dx = p.ex - ox;
    dy = p.ey - oy;
    d1x = p.b1x - ox;
    d1y = p.b1y - oy;
    d2x = p.b2x - ox;
    d2y = p.b2y - oy;
    l2 = dx * dx + dy * dy;
    if (l2 == 0) return r;
    p1 = dx * d1x + dy * d1y;
    p2 = dx * d2x + dy * d2y;
    if (p1 <= 0 && p2 <= 0) return r;
    if (p1 >= l2 && p2 >= l2) return r;
    s1 = dy * d1x - dx * d1y;
    s2 = dy * d2x - dx * d2y;
    if ((s1 > 0 && s2 > 0) || (s1 < 0 && s2 < 0)) return r;
    if (s1 == s2) return r;
    n = d1x * d2y - d1y * d2x;
    dp = dx * (d2y - d1y) - dy * (d2x - d1x);
    if (dp < 0) begin
      dp = -dp;
      n = -n;
    end
    if (n <= 0 || n >= dp) return r;
    uq = $unsigned(n <<< 32) / $unsigned(dp);
    rad = $unsigned(l2) << sit_pkg::SQRT_SHIFT;
    lf = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = lf | (128'(1) << b);
      if (cand * cand <= rad) lf = cand;
    end
    prod = (uq * lf) >> 32;
    r.hit = 1'b1;
    r.distance = (prod > sit_pkg::DIST_MAX) ? sit_pkg::DIST_MAX
                                            : prod[sit_pkg::DIST_WIDTH-1:0];
    return r;
  endfunction

  // random pair: mostly B placed across a point of A, some pure noise
  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int t, tx, ty, ox, oy, lim;
    lim = ($urandom_range(0, 3) == 0) ? 16000 : 600;
    p = {$urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 4) == 0) return p;
    p.ax = CW'($signed($urandom_range(0, 2 * lim)) - lim);
    p.ay = CW'($signed($urandom_range(0, 2 * lim)) - lim);
    p.ex = CW'($signed($urandom_range(0, 2 * lim)) - lim);
    p.ey = CW'($signed($urandom_range(0, 2 * lim)) - lim);
    t = $urandom_range(0, 64);
    tx = p.ax + ((p.ex - p.ax) * t) / 64;
    ty = p.ay + ((p.ey - p.ay) * t) / 64;
    ox = $signed($urandom_range(0, 2 * lim)) - lim;
    oy = $signed($urandom_range(0, 2 * lim)) - lim;
    if ($urandom_range(0, 7) == 0) begin
      ox = 0;
    end
    p.b1x = CW'(tx + ox);
    p.b1y = CW'(ty + oy);
    p.b2x = CW'(tx - ox / int'($urandom_range(1, 3)));
    p.b2y = CW'(ty - oy / int'($urandom_range(1, 3)));
    return p;
  endfunction

  // directed rows: known misses, one exact midpoint crossing, and untyped corner cases
  initial begin
    directed_rows[0] = '{'{16'sd5, 16'sd5, 16'sd5, 16'sd5, -16'sd1, 16'sd0, 16'sd9, 16'sd0},
                         1'b1, '{1'b0, '0}};
    directed_rows[1] = '{'{16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd128, -16'sd16, 16'sd128, 16'sd16},
                         1'b1, '{1'b1, 25'd32768}};
    directed_rows[2] = '{'{16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, -16'sd16, 16'sd0, 16'sd16},
                         1'b1, '{1'b0, '0}};
    directed_rows[3] = '{'{16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd256, -16'sd16, 16'sd256, 16'sd16},
                         1'b1, '{1'b0, '0}};
    directed_rows[4] = '{'{16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd10, 16'sd0, 16'sd90, 16'sd0},
                         1'b1, '{1'b0, '0}};
    directed_rows[5] = '{'{16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd100, 16'sd5, 16'sd150, 16'sd9},
                         1'b1, '{1'b0, '0}};
    directed_rows[6] = '{'{16'sd0, 16'sd0, 16'sd256, 16'sd0, -16'sd10, -16'sd5, -16'sd20, 16'sd9},
                         1'b1, '{1'b0, '0}};
    directed_rows[7] = '{'{16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd300, -16'sd5, 16'sd400, 16'sd9},
                         1'b1, '{1'b0, '0}};
    directed_rows[8] = '{'{16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd128, 16'sd0, 16'sd128, 16'sd16},
                         1'b0, '{1'b0, '0}};
    directed_rows[9] = '{'{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                           16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000}, 1'b0, '{1'b0, '0}};
    directed_rows[10] = '{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                            16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b1, '{1'b0, '0}};
    directed_rows[11] = '{'{16'sh8000, 16'sh0, 16'sh7fff, 16'sh0,
                            16'sh0, 16'sh8000, 16'sh1, 16'sh7fff}, 1'b0, '{1'b0, '0}};
  end

  // request driver with bursts, gaps and one drain pause
  initial begin
    int idx, burst, gap;
    bit paused;
    crossing_t want;
    idx = 0;
    burst = $urandom_range(1, 40);
    gap = 0;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (idx < NUM_ITEMS) begin
      @(posedge clk);
      if (in_push && !in_full) begin
        if (idx < NUM_DIRECTED && directed_rows[idx].typed) want = directed_rows[idx].want;
        else want = predict_crossing(cur);
        expected_crossings.insert(expected_crossings.size(), want);
        idx++;
        if (idx == HOLD_AT) hold_req = 1'b1;
      end
      if (in_push && in_full) begin
        // keep offering the same request
      end else if (idx == NUM_ITEMS) begin
        in_push <= 1'b0;
      end else if (idx == PAUSE_AT && !paused) begin
        in_push <= 1'b0;
        if (expected_crossings.size() == 0) paused = 1'b1;
      end else if (gap > 0) begin
        in_push <= 1'b0;
        gap--;
      end else begin
        cur <= (idx < NUM_DIRECTED) ? directed_rows[idx].pair : random_pair();
        in_push <= 1'b1;
        burst--;
        if (burst <= 0) begin
          burst = $urandom_range(1, 40);
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    stim_done = 1'b1;
  end

  // result receiver with its own stall pattern and one long hold
  initial begin
    int cyc, mode;
    cyc = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_pop <= 1'b1;
        1: out_pop <= 1'($urandom_range(0, 1));
        default: out_pop <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // compare each popped result with the oldest expectation
  always @(posedge clk) begin
    crossing_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_crossings.size() == 0) begin
        $error("unexpected result: hit %0d distance %0d", out_hit, out_crossing_distance);
        errors++;
      end else begin
        want = expected_crossings.pop_front();
        if (out_hit !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, out_hit);
          errors++;
        end
        if (out_crossing_distance !== want.distance) begin
          $error("crossing_distance: expected %0d, actual %0d",
                 want.distance, out_crossing_distance);
          errors++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (expected_crossings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // timeout
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/sit_pkg.sv
rtl/core/sit_front.sv
rtl/core/sit_queue.sv
rtl/core/sit_back.sv
rtl/core/segment_intersection_test_top.sv
bench/segment_intersection_test_top_tb.sv
